// ===== rtl/dsms_pkg.sv =====
// shared types, constants and helpers for the dual stepper move sequencer
// no dependencies
package dsms_pkg;

    localparam int COUNT_BITS       = 16;
    localparam int TICKS_AT_ONE_RPM = 29297;

    localparam int CMD_W    = 2;
    localparam int STEP_W   = 16;
    localparam int RPM_W    = 8;
    localparam int PINS_W   = 8;
    localparam int PERIOD_W = 15;
    localparam int MAG_W    = STEP_W + 1;

    localparam int DIV_W  = $clog2(TICKS_AT_ONE_RPM + 1);
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int QX_W   = (DIV_W > PERIOD_W) ? DIV_W : PERIOD_W;
    localparam int SX_W   = (MAG_W > COUNT_BITS) ? MAG_W : COUNT_BITS;

    localparam logic [DIV_W-1:0]      DIVIDEND   = DIV_W'(TICKS_AT_ONE_RPM);
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                     apply;
        cmd_t                     cmd;
        logic                     motion;
        logic signed [STEP_W-1:0] step_count;
    } core_op_t;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              busy;
        logic              strobe;
    } core_res_t;

    // coil index per pin for straight fwd, turn fwd, straight rev, turn rev
    localparam logic [1:0] PIN_COIL [4][PINS_W] = '{
        '{2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0}
    };

    function automatic logic [PINS_W-1:0] pin_map(input logic [3:0] coils,
                                                  input logic [1:0] kind);
        logic [PINS_W-1:0] pins;
        pins = '0;
        for (int i = 0; i < PINS_W; i++) begin
            pins[i] = coils[PIN_COIL[kind][i]];
        end
        return pins;
    endfunction

endpackage

// ===== rtl/dsms_div.sv =====
// restoring divider, one quotient bit per cycle: step period from rpm
// depends on dsms_pkg
module dsms_div import dsms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RPM_W-1:0]  rpm,
    output logic              busy,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RPM_W-1:0]  rem_reg, rem_next;
    logic [RPM_W-1:0]  dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [RPM_W:0]    trial;
    logic [RPM_W:0]    diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        q_reg    <= q_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        q_next    = q_reg;
        trial     = {rem_reg, q_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            rem_next  = '0;
            dvsr_next = (rpm == '0) ? RPM_W'(1) : rpm;
            q_next    = DIVIDEND;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvsr_reg}) begin
                rem_next = diff[RPM_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[RPM_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/dsms_core.sv =====
// move state: step counter, tick countdown, phase and coil pattern to pins
// depends on dsms_pkg
module dsms_core import dsms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_mode,
    input  core_op_t          op,
    input  logic [DIV_W-1:0]  quotient,
    output core_res_t         res
);

    logic [COUNT_BITS-1:0] steps_reg, steps_next;
    logic [1:0]            phase_reg, phase_next;
    logic [PERIOD_W-1:0]   cd_reg, cd_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [1:0]            kind_reg, kind_next;
    logic [PINS_W-1:0]     pins_reg, pins_next;

    logic                  do_step;
    logic [PERIOD_W-1:0]   cd_dec;
    logic                  reverse;
    logic [MAG_W-1:0]      mag;
    logic [SX_W-1:0]       mag_ext;
    logic [COUNT_BITS-1:0] steps_sat;
    logic [QX_W-1:0]       q_ext;
    logic [PERIOD_W-1:0]   period_sat;
    logic [3:0]            coils;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg  <= '0;
            phase_reg  <= '0;
            cd_reg     <= '0;
            period_reg <= '0;
            kind_reg   <= '0;
            pins_reg   <= '0;
        end else if (op.apply) begin
            steps_reg  <= steps_next;
            phase_reg  <= phase_next;
            cd_reg     <= cd_next;
            period_reg <= period_next;
            kind_reg   <= kind_next;
            pins_reg   <= pins_next;
        end
    end

    always_comb begin
        reverse    = op.step_count[STEP_W-1];
        mag        = reverse ? (MAG_W'(1 << STEP_W) - {1'b0, op.step_count})
                             : {1'b0, op.step_count};
        mag_ext    = SX_W'(mag);
        steps_sat  = (mag_ext > SX_W'(COUNT_MAX)) ? COUNT_MAX
                                                  : mag_ext[COUNT_BITS-1:0];
        q_ext      = QX_W'(quotient);
        period_sat = (q_ext > QX_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                 : q_ext[PERIOD_W-1:0];
        cd_dec     = (cd_reg != '0) ? (cd_reg - PERIOD_W'(1)) : cd_reg;

        steps_next  = steps_reg;
        phase_next  = phase_reg;
        cd_next     = cd_reg;
        period_next = period_reg;
        kind_next   = kind_reg;
        pins_next   = pins_reg;
        do_step     = 1'b0;

        unique case (op.cmd)
            CMD_TICK: begin
                cd_next = cd_dec;
                do_step = (cd_dec == '0) && (steps_reg != '0);
            end
            CMD_START: begin
                period_next = period_sat;
                steps_next  = steps_sat;
                kind_next   = {reverse, op.motion};
                phase_next  = '0;
                cd_next     = '0;
                do_step     = (steps_sat != '0);
            end
            CMD_STOP: begin
                pins_next  = '0;
                steps_next = '0;
                cd_next    = '0;
            end
            default: begin
            end
        endcase

        coils = '0;
        if (do_step) begin
            phase_next = phase_next + 2'd1;
            coils      = 4'b0001 << phase_next;
            if (step_mode) begin
                coils = coils | (4'b0001 << (phase_next + 2'd1));
            end
            pins_next  = pin_map(coils, kind_next);
            steps_next = steps_next - COUNT_BITS'(1);
            cd_next    = period_next;
        end

        res.pins   = pins_next;
        res.busy   = (steps_next != '0) || (cd_next != '0);
        res.strobe = do_step;
    end

endmodule

// ===== rtl/dual_stepper_move_sequencer_unit.sv =====
// top level of the dual stepper move sequencer: handshakes, result register
// depends on dsms_pkg, dsms_div, dsms_core
//
// Every accepted word gives one result word. Tick, stop and unused command
// words are applied when accepted, so a tick can be accepted every clock
// while the result slot drains. A start word keeps the input stalled while
// the step period, the tick constant divided by rpm, is formed by a
// restoring divider one quotient bit per cycle and the move is then
// loaded, with its first step made if it has any steps.
// step_mode is sampled at every step and should be written only while idle.
module dual_stepper_move_sequencer_unit import dsms_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic                     cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic                     s_motion,
    input  logic signed [STEP_W-1:0] s_step_count,
    input  logic [RPM_W-1:0]         s_speed_rpm,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PINS_W-1:0]        m_coil_pins,
    output logic                     m_busy_res,
    output logic                     m_step_strobe
);

    logic                     step_mode_reg;
    logic                     m_valid_reg;
    logic [PINS_W-1:0]        pins_reg;
    logic                     busy_reg;
    logic                     strobe_reg;
    logic                     motion_reg;
    logic signed [STEP_W-1:0] count_reg;

    logic                     accept;
    logic                     is_start;
    logic                     div_busy;
    logic                     div_done;
    logic [DIV_W-1:0]         quotient;
    core_op_t                 op;
    core_res_t                res;

    assign s_ready  = !div_busy && !div_done && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_start = (cmd_t'(s_command) == CMD_START);

    always_comb begin
        if (div_done) begin
            op.apply      = 1'b1;
            op.cmd        = CMD_START;
            op.motion     = motion_reg;
            op.step_count = count_reg;
        end else begin
            op.apply      = accept && !is_start;
            op.cmd        = cmd_t'(s_command);
            op.motion     = s_motion;
            op.step_count = s_step_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mode_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                step_mode_reg <= cfg_wdata;
            end
            if (op.apply) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (op.apply) begin
            pins_reg   <= res.pins;
            busy_reg   <= res.busy;
            strobe_reg <= res.strobe;
        end
        if (accept && is_start) begin
            motion_reg <= s_motion;
            count_reg  <= s_step_count;
        end
    end

    dsms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && is_start),
        .rpm      (s_speed_rpm),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    dsms_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_mode (step_mode_reg),
        .op        (op),
        .quotient  (quotient),
        .res       (res)
    );

    assign m_valid       = m_valid_reg;
    assign m_coil_pins   = pins_reg;
    assign m_busy_res    = busy_reg;
    assign m_step_strobe = strobe_reg;

endmodule
